FILE: design/rpr_pkg.sv
// Range-partition router: shared types and constants.
// Payload structs for both channels, opcode enums and pipeline stage records.
// No dependencies.
package rpr_pkg;

  localparam int TABLE_SLOTS      = 16;
  localparam int MAX_PARTITIONS_D = 16;
  localparam int COUNT_W          = 5;
  localparam int COLUMN_W         = 8;
  localparam int SLOT_W           = 4;
  localparam int KEY_W            = 64;
  localparam int CFG_DATA_W       = 8;
  localparam int CFG_INDEX_W      = 1;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_ROUTE    = 2'd1,
    OP_PRUNE    = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMP_EQ = 3'd0,
    CMP_LT = 3'd1,
    CMP_LE = 3'd2,
    CMP_GT = 3'd3,
    CMP_GE = 3'd4,
    CMP_NE = 3'd5
  } cmp_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PART_COUNT  = 1'd0,
    CFG_PART_COLUMN = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    op_t                     operation;
    logic [SLOT_W-1:0]       entry_index;
    logic signed [KEY_W-1:0] bound_value;
    logic                    bound_is_max;
    logic signed [KEY_W-1:0] key_value;
    logic                    key_is_null;
    logic [COLUMN_W-1:0]     predicate_column;
    logic [2:0]              compare_op;
  } in_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0]      shard_index;
    logic [TABLE_SLOTS-1:0] partition_mask;
    logic                   table_empty;
  } out_beat_t;

  // compare results against every entry
  typedef struct packed {
    op_t                    operation;
    logic                   key_is_null;
    logic                   col_match;
    logic [2:0]             compare_op;
    logic [TABLE_SLOTS-1:0] key_lt_bound;
    logic [TABLE_SLOTS-1:0] bound_lt_key;
    logic [TABLE_SLOTS-1:0] max_flag;
    logic [TABLE_SLOTS-1:0] in_use;
    logic                   none_in_use;
    logic [SLOT_W-1:0]      last_idx;
  } cmp_stage_t;

  // per-entry candidate vectors
  typedef struct packed {
    op_t                    operation;
    logic                   col_match;
    logic [TABLE_SLOTS-1:0] route_cand;
    logic [TABLE_SLOTS-1:0] prune_hits;
    logic [TABLE_SLOTS-1:0] in_use;
    logic                   none_in_use;
    logic [SLOT_W-1:0]      last_idx;
  } sel_stage_t;

endpackage

FILE: design/range_partition_router_unit.sv
// Range-partition router top level: table storage and four-stage pipeline.
// Depends on rpr_pkg.
//
//  channel | ports                          | beat
//  in      | in_valid, in_stall, in_data    | rpr_pkg::in_beat_t, load/route/prune
//  out     | out_valid, out_stall, out_data | rpr_pkg::out_beat_t, one per input beat
//  cfg     | cfg_we, cfg_index, cfg_data    | partition_count, partition_column
//
// One beat enters per cycle unless out_stall holds the pipe; its result passes through
// the input reg, 64-bit compare stage, candidate stage and select/output reg.
// Loads write the table when accepted, so the next beat already sees them.
// out_stall freezes the whole pipe while out_valid is high; in_stall follows it then.
// Reset clears max flags, config and valids; bounds stay undefined until loaded.
module range_partition_router_unit #(
  parameter int MAX_PARTITIONS = rpr_pkg::MAX_PARTITIONS_D
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rpr_pkg::in_beat_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rpr_pkg::out_beat_t                  out_data,
  input  logic                                cfg_we,
  input  logic [rpr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rpr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH = (MAX_PARTITIONS < rpr_pkg::TABLE_SLOTS) ?
                         MAX_PARTITIONS : rpr_pkg::TABLE_SLOTS;
  localparam int NS = rpr_pkg::TABLE_SLOTS;

  logic signed [rpr_pkg::KEY_W-1:0] bounds_r [DEPTH];
  logic [DEPTH-1:0]                 max_r;
  logic [rpr_pkg::COUNT_W-1:0]      count_r;
  logic [rpr_pkg::COLUMN_W-1:0]     column_r;

  logic                s1_v_r, s2_v_r, s3_v_r, out_v_r;
  rpr_pkg::in_beat_t   s1_r;
  rpr_pkg::cmp_stage_t s2_r, s2_nxt;
  rpr_pkg::sel_stage_t s3_r, s3_nxt;
  rpr_pkg::out_beat_t  out_r, out_nxt;

  logic                        adv;
  logic                        in_acc;
  logic [rpr_pkg::COUNT_W-1:0] n_used;
  logic [NS-1:0]               in_use_w;

  assign adv       = !out_v_r || !out_stall;
  assign in_stall  = !adv;
  assign in_acc    = in_valid && adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign n_used = (count_r > rpr_pkg::COUNT_W'(DEPTH)) ?
                  rpr_pkg::COUNT_W'(DEPTH) : count_r;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      in_use_w[i] = rpr_pkg::COUNT_W'(i) < n_used;
    end
  end

  // config, flags, valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r    <= '0;
      count_r  <= '0;
      column_r <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (rpr_pkg::cfg_reg_t'(cfg_index))
          rpr_pkg::CFG_PART_COUNT:  count_r  <= cfg_data[rpr_pkg::COUNT_W-1:0];
          rpr_pkg::CFG_PART_COLUMN: column_r <= cfg_data[rpr_pkg::COLUMN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && in_data.operation == rpr_pkg::OP_LOAD) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (in_data.entry_index == rpr_pkg::SLOT_W'(i)) begin
            max_r[i] <= in_data.bound_is_max;
          end
        end
      end
      if (adv) begin
        s1_v_r  <= in_valid;
        s2_v_r  <= s1_v_r;
        s3_v_r  <= s2_v_r;
        out_v_r <= s3_v_r;
      end
    end
  end

  // bounds and stage payloads
  always_ff @(posedge clk) begin
    if (in_acc && in_data.operation == rpr_pkg::OP_LOAD) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (in_data.entry_index == rpr_pkg::SLOT_W'(i)) begin
          bounds_r[i] <= in_data.bound_value;
        end
      end
    end
    if (adv) begin
      s1_r  <= in_data;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      out_r <= out_nxt;
    end
  end

  // stage 2: compare key against every bound
  always_comb begin
    s2_nxt              = '0;
    s2_nxt.operation    = s1_r.operation;
    s2_nxt.key_is_null  = s1_r.key_is_null;
    s2_nxt.col_match    = s1_r.predicate_column == column_r;
    s2_nxt.compare_op   = s1_r.compare_op;
    s2_nxt.in_use       = in_use_w;
    s2_nxt.none_in_use  = n_used == '0;
    s2_nxt.last_idx     = rpr_pkg::SLOT_W'(n_used - rpr_pkg::COUNT_W'(1));
    for (int i = 0; i < DEPTH; i++) begin
      s2_nxt.key_lt_bound[i] = s1_r.key_value < bounds_r[i];
      s2_nxt.bound_lt_key[i] = bounds_r[i] < s1_r.key_value;
      s2_nxt.max_flag[i]     = max_r[i];
    end
  end

  // stage 3: per-entry route candidates and prune hits
  always_comb begin
    logic [NS-1:0] prev_le;
    logic [NS-1:0] prev_lt;
    logic          seen_max;
    logic          hit;
    prev_le  = {~s2_r.key_lt_bound[NS-2:0], 1'b1};
    prev_lt  = {s2_r.bound_lt_key[NS-2:0], 1'b1};
    seen_max = 1'b0;
    hit      = 1'b0;
    s3_nxt             = '0;
    s3_nxt.operation   = s2_r.operation;
    s3_nxt.col_match   = s2_r.col_match;
    s3_nxt.in_use      = s2_r.in_use;
    s3_nxt.none_in_use = s2_r.none_in_use;
    s3_nxt.last_idx    = s2_r.last_idx;
    for (int i = 0; i < NS; i++) begin
      case (s2_r.compare_op)
        rpr_pkg::CMP_EQ: hit = prev_le[i] && s2_r.key_lt_bound[i];
        rpr_pkg::CMP_LT: hit = prev_lt[i];
        rpr_pkg::CMP_LE: hit = prev_le[i];
        rpr_pkg::CMP_GT,
        rpr_pkg::CMP_GE: hit = s2_r.key_lt_bound[i];
        default:         hit = 1'b1;
      endcase
      s3_nxt.route_cand[i] = s2_r.in_use[i] &&
                             (s2_r.max_flag[i] || (!s2_r.key_is_null && s2_r.key_lt_bound[i]));
      s3_nxt.prune_hits[i] = s2_r.in_use[i] && !seen_max && (s2_r.max_flag[i] || hit);
      seen_max = seen_max || s2_r.max_flag[i];
    end
  end

  // stage 4: pick shard, finalize mask
  always_comb begin
    logic [rpr_pkg::SLOT_W-1:0] first_idx;
    logic                       found;
    first_idx = '0;
    found     = 1'b0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (s3_r.route_cand[i]) begin
        first_idx = rpr_pkg::SLOT_W'(i);
        found     = 1'b1;
      end
    end
    out_nxt = '0;
    case (s3_r.operation)
      rpr_pkg::OP_ROUTE: begin
        out_nxt.table_empty = s3_r.none_in_use;
        if (!s3_r.none_in_use) begin
          out_nxt.shard_index = found ? first_idx : s3_r.last_idx;
        end
      end
      rpr_pkg::OP_PRUNE: begin
        out_nxt.partition_mask = (!s3_r.col_match || s3_r.prune_hits == '0) ?
                                 s3_r.in_use : s3_r.prune_hits;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && adv) |=> s2_v_r)
    else $error("stage 1 beat lost while advancing");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.table_empty) |->
      (out_data.shard_index == '0 && out_data.partition_mask == '0))
    else $error("table_empty result carries nonzero fields");

  a_mask_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && adv && s3_r.operation == rpr_pkg::OP_PRUNE) |=>
      ((out_data.partition_mask & ~$past(s3_r.in_use)) == '0))
    else $error("prune mask selects an entry not in use");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for range_partition_router_unit: loads, routes and prunes
// checked beat by beat against an in-bench table predictor, under varied idling.
// Depends on rpr_pkg and the router RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 300000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rpr_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rpr_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [rpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  range_partition_router_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of table and registers
  logic signed [rpr_pkg::KEY_W-1:0] bound_tbl[rpr_pkg::TABLE_SLOTS];
  logic max_tbl[rpr_pkg::TABLE_SLOTS];
  logic [rpr_pkg::COUNT_W-1:0] tbl_count = '0;
  logic [rpr_pkg::COLUMN_W-1:0] tbl_column = '0;

  rpr_pkg::out_beat_t shard_answers[$];
  rpr_pkg::out_beat_t want;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic flag_mismatch(string what, rpr_pkg::out_beat_t exp_b,
                               rpr_pkg::out_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): exp shard %0d mask %h empty %0d, got shard %0d mask %h empty %0d",
               what, exp_b.shard_index, exp_b.partition_mask, exp_b.table_empty,
               got.shard_index, got.partition_mask, got.table_empty);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (shard_answers.size() == 0) begin
        flag_mismatch("no beat expected", '0, out_data);
      end else begin
        want = shard_answers.pop_front();
        if (out_data.shard_index !== want.shard_index ||
            out_data.partition_mask !== want.partition_mask ||
            out_data.table_empty !== want.table_empty)
          flag_mismatch("field", want, out_data);
      end
    end
  end

  function automatic int entries_used();
    return (tbl_count > 5'd16) ? 16 : int'(tbl_count);
  endfunction

  function automatic logic [rpr_pkg::SLOT_W-1:0] pick_shard(
      logic signed [rpr_pkg::KEY_W-1:0] key, logic is_null, int n);
    for (int i = 0; i < n; i++) begin
      if (max_tbl[i]) return rpr_pkg::SLOT_W'(i);
      if (!is_null && key < bound_tbl[i]) return rpr_pkg::SLOT_W'(i);
    end
    return rpr_pkg::SLOT_W'(n - 1);
  endfunction

  function automatic logic [rpr_pkg::TABLE_SLOTS-1:0] prune_mask(
      logic signed [rpr_pkg::KEY_W-1:0] lit, logic [2:0] op, int n);
    logic [rpr_pkg::TABLE_SLOTS-1:0] all_used;
    logic [rpr_pkg::TABLE_SLOTS-1:0] hits;
    logic signed [rpr_pkg::KEY_W-1:0] prev;
    logic has_lower;
    logic hit;
    all_used = (n >= 16) ? 16'hFFFF : 16'((32'd1 << n) - 1);
    hits = '0;
    has_lower = 1'b0;
    prev = '0;
    for (int i = 0; i < n; i++) begin
      if (max_tbl[i]) begin
        hits[i] = 1'b1;
        break;
      end
      case (op)
        rpr_pkg::CMP_EQ: hit = (!has_lower || prev <= lit) && lit < bound_tbl[i];
        rpr_pkg::CMP_LT: hit = !has_lower || prev < lit;
        rpr_pkg::CMP_LE: hit = !has_lower || prev <= lit;
        rpr_pkg::CMP_GT, rpr_pkg::CMP_GE: hit = bound_tbl[i] > lit;
        default: hit = 1'b1;
      endcase
      if (hit) hits[i] = 1'b1;
      has_lower = 1'b1;
      prev = bound_tbl[i];
    end
    return (hits == '0) ? all_used : hits;
  endfunction

  task automatic apply_beat_to_table(rpr_pkg::in_beat_t b);
    rpr_pkg::out_beat_t r;
    int n;
    r = '0;
    n = entries_used();
    case (b.operation)
      rpr_pkg::OP_LOAD: begin
        bound_tbl[b.entry_index] = b.bound_value;
        max_tbl[b.entry_index] = b.bound_is_max;
      end
      rpr_pkg::OP_ROUTE: begin
        if (n == 0) r.table_empty = 1'b1;
        else r.shard_index = pick_shard(b.key_value, b.key_is_null, n);
      end
      rpr_pkg::OP_PRUNE: begin
        if (b.predicate_column != tbl_column)
          r.partition_mask = (n >= 16) ? 16'hFFFF : 16'((32'd1 << n) - 1);
        else
          r.partition_mask = prune_mask(b.key_value, b.compare_op, n);
      end
      default: ;
    endcase
    shard_answers = {shard_answers, r};
  endtask

  task automatic send_beat(rpr_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    apply_beat_to_table(b);
  endtask

  function automatic rpr_pkg::in_beat_t noise_beat();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(rpr_pkg::in_beat_t)-1:0];
  endfunction

  task automatic load_entry(int idx, logic signed [rpr_pkg::KEY_W-1:0] bound,
                            logic is_max);
    rpr_pkg::in_beat_t b;
    b = noise_beat();
    b.operation = rpr_pkg::OP_LOAD;
    b.entry_index = rpr_pkg::SLOT_W'(idx);
    b.bound_value = bound;
    b.bound_is_max = is_max;
    send_beat(b);
  endtask

  task automatic route_key(logic signed [rpr_pkg::KEY_W-1:0] key, logic is_null);
    rpr_pkg::in_beat_t b;
    b = noise_beat();
    b.operation = rpr_pkg::OP_ROUTE;
    b.key_value = key;
    b.key_is_null = is_null;
    send_beat(b);
  endtask

  task automatic prune_on(logic [rpr_pkg::COLUMN_W-1:0] col, logic [2:0] op,
                          logic signed [rpr_pkg::KEY_W-1:0] lit);
    rpr_pkg::in_beat_t b;
    b = noise_beat();
    b.operation = rpr_pkg::OP_PRUNE;
    b.predicate_column = col;
    b.compare_op = op;
    b.key_value = lit;
    send_beat(b);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (shard_answers.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(rpr_pkg::cfg_reg_t which,
                           logic [rpr_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == rpr_pkg::CFG_PART_COUNT) tbl_count = value[rpr_pkg::COUNT_W-1:0];
    else tbl_column = value;
    @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  task automatic test_empty_table();
    rpr_pkg::in_beat_t b;
    route_key(64'sd5, 1'b0);
    route_key(64'sd0, 1'b1);
    prune_on(8'd0, rpr_pkg::CMP_EQ, 64'sd0);
    b = noise_beat();
    b.operation = rpr_pkg::OP_RESERVED;
    send_beat(b);
    wait_idle();
  endtask

  task automatic test_route_directed();
    load_entry(0, -64'sd100, 1'b0);
    load_entry(1, 64'sd0, 1'b0);
    load_entry(2, 64'sd100, 1'b0);
    load_entry(3, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);
    wait_idle();
    write_reg(rpr_pkg::CFG_PART_COUNT, 8'd4);
    write_reg(rpr_pkg::CFG_PART_COLUMN, 8'd7);
    route_key(64'sh8000_0000_0000_0000, 1'b0);
    route_key(-64'sd100, 1'b0);
    route_key(64'sd99, 1'b0);
    route_key(64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);
    route_key(64'sd99, 1'b1);
  endtask

  task automatic test_prune_directed();
    prune_on(8'd7, rpr_pkg::CMP_EQ, 64'sd0);
    prune_on(8'd7, rpr_pkg::CMP_LT, 64'sd0);
    prune_on(8'd7, rpr_pkg::CMP_LE, 64'sd0);
    prune_on(8'd7, rpr_pkg::CMP_GT, 64'sd100);
    prune_on(8'd7, rpr_pkg::CMP_GE, 64'sh7FFF_FFFF_FFFF_FFFF);
    prune_on(8'd7, rpr_pkg::CMP_NE, 64'sd3);
    prune_on(8'd7, 3'd6, 64'sd3);
    prune_on(8'd7, 3'd7, 64'sd3);
    prune_on(8'd8, rpr_pkg::CMP_EQ, 64'sd0);
  endtask

  task automatic test_max_partition();
    load_entry(2, 64'sd100, 1'b1);
    route_key(64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);
    route_key(64'sd0, 1'b1);
    prune_on(8'd7, rpr_pkg::CMP_GT, 64'sh7FFF_FFFF_FFFF_FFFF);
    wait_idle();
  endtask

  task automatic build_table(bit narrow, bit sorted);
    logic signed [rpr_pkg::KEY_W-1:0] vals[rpr_pkg::TABLE_SLOTS];
    logic signed [rpr_pkg::KEY_W-1:0] t;
    int max_at;
    for (int i = 0; i < rpr_pkg::TABLE_SLOTS; i++) begin
      if (narrow) vals[i] = $signed($urandom_range(2000)) - 1000;
      else vals[i] = {$urandom, $urandom};
    end
    if (sorted) begin
      for (int i = 0; i < rpr_pkg::TABLE_SLOTS - 1; i++)
        for (int j = 0; j < rpr_pkg::TABLE_SLOTS - 1 - i; j++)
          if (vals[j] > vals[j+1]) begin
            t = vals[j];
            vals[j] = vals[j+1];
            vals[j+1] = t;
          end
    end
    max_at = $urandom_range(1) ? $urandom_range(15) : rpr_pkg::TABLE_SLOTS;
    for (int i = 0; i < rpr_pkg::TABLE_SLOTS; i++)
      load_entry(i, vals[i], i == max_at);
    wait_idle();
  endtask

  function automatic logic signed [rpr_pkg::KEY_W-1:0] pick_key();
    logic signed [rpr_pkg::KEY_W-1:0] k;
    case ($urandom_range(5))
      0: k = {$urandom, $urandom};
      1: k = 64'sh8000_0000_0000_0000;
      2: k = 64'sh7FFF_FFFF_FFFF_FFFF;
      default: k = bound_tbl[$urandom_range(15)] + ($signed($urandom_range(2)) - 1);
    endcase
    return k;
  endfunction

  task automatic test_random_traffic();
    logic [rpr_pkg::CFG_DATA_W-1:0] count_val;
    logic [rpr_pkg::CFG_DATA_W-1:0] col_val;
    logic [rpr_pkg::COLUMN_W-1:0] col;
    int pick;
    rpr_pkg::in_beat_t b;
    for (int p = 0; p < 8; p++) begin
      set_idling(p % 4);
      build_table($urandom_range(1), $urandom_range(7) != 0);
      case (p)
        0: count_val = 8'd16;
        1: count_val = 8'd31;
        2: count_val = 8'd0;
        3: count_val = 8'd1;
        4: count_val = $urandom_range(255);
        default: count_val = $urandom_range(16, 2);
      endcase
      case (p)
        0: col_val = 8'd255;
        1: col_val = 8'd0;
        default: col_val = $urandom_range(255);
      endcase
      write_reg(rpr_pkg::CFG_PART_COUNT, count_val);
      write_reg(rpr_pkg::CFG_PART_COLUMN, col_val);
      repeat (37) begin
        pick = $urandom_range(99);
        col = ($urandom_range(4) != 0) ? tbl_column :
              rpr_pkg::COLUMN_W'($urandom_range(255));
        if (pick < 10) begin
          load_entry($urandom_range(15), pick_key(), $urandom_range(9) == 0);
        end else if (pick < 13) begin
          b = noise_beat();
          b.operation = rpr_pkg::OP_RESERVED;
          send_beat(b);
        end else if (pick < 58) begin
          route_key(pick_key(), $urandom_range(6) == 0);
        end else begin
          prune_on(col, 3'($urandom_range(7)), pick_key());
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    for (int i = 0; i < rpr_pkg::TABLE_SLOTS; i++) begin
      bound_tbl[i] = '0;
      max_tbl[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(3);
    test_empty_table();
    test_route_directed();
    test_prune_directed();
    test_max_partition();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && shard_answers.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/rpr_pkg.sv
design/range_partition_router_unit.sv
tb/tb_top.sv
